### rtl/bcc_pkg.sv
// Package with the payload types and class codes of the button click classifier.
`default_nettype none

package bcc_pkg;

	// Class codes, shared by prev_class and press_class.
	localparam logic [2:0] CLS_NONE       = 3'd0;
	localparam logic [2:0] CLS_SHORT      = 3'd1;
	localparam logic [2:0] CLS_LONG       = 3'd2;
	localparam logic [2:0] CLS_DOUBLE     = 3'd3;
	localparam logic [2:0] CLS_TRIPLE     = 3'd4;
	localparam logic [2:0] CLS_SUS_DOUBLE = 3'd5;
	localparam logic [2:0] CLS_SUS_TRIPLE = 3'd6;

	// Configuration register indexes.
	localparam logic [1:0] REG_SPACING = 2'd0;
	localparam logic [1:0] REG_LONG    = 2'd1;
	localparam logic [1:0] REG_SCAN    = 2'd2;

	localparam logic [23:0] SPACING_RST = 24'd300000;
	localparam logic [23:0] LONG_RST    = 24'd1000000;
	localparam logic [23:0] SCAN_RST    = 24'd50000;

	typedef struct packed {
		logic [31:0] now_us;
		logic [31:0] pressed_stamp;
		logic [31:0] released_stamp;
		logic [2:0]  prev_class;
	} bcc_in_t;

	typedef struct packed {
		logic [2:0] press_class;
		logic       clear_stamps;
	} bcc_out_t;

	typedef struct packed {
		logic [23:0] join_gap_us;
		logic [23:0] long_press_us;
		logic [23:0] scan_interval_us;
	} bcc_cfg_t;

	// Update of the remembered release stamp.
	typedef struct packed {
		logic        we;
		logic [31:0] value;
	} bcc_upd_t;

endpackage

`default_nettype wire

### rtl/bcc_classify.sv
// Combinational classification of one registered button sample.
`default_nettype none

module bcc_classify (
	input  bcc_pkg::bcc_in_t  item,
	input  bcc_pkg::bcc_cfg_t cfg,
	input  logic [31:0]       last_release,
	output bcc_pkg::bcc_out_t result,
	output bcc_pkg::bcc_upd_t upd
);
	import bcc_pkg::*;

	logic [31:0] hold_rel;
	logic [31:0] gap;
	logic [31:0] hold_held;
	logic [24:0] upper;
	logic [31:0] long_ext;
	logic [31:0] spc_ext;
	logic        short_hold;
	logic        gap_gt;
	logic        gap_lt;
	logic        held_long;
	logic        held_in_win;
	logic        same_rel;

	assign long_ext    = {8'd0, cfg.long_press_us};
	assign spc_ext     = {8'd0, cfg.join_gap_us};
	assign hold_rel    = item.released_stamp - item.pressed_stamp;
	assign gap         = item.now_us - item.released_stamp;
	assign hold_held   = item.now_us - item.pressed_stamp;
	assign upper       = {1'b0, cfg.long_press_us} + {1'b0, cfg.scan_interval_us};
	assign short_hold  = hold_rel < long_ext;
	assign gap_gt      = gap > spc_ext;
	assign gap_lt      = gap < spc_ext;
	assign held_long   = hold_held >= long_ext;
	assign held_in_win = hold_held < {7'd0, upper};
	assign same_rel    = item.released_stamp == last_release;

	always_comb begin
		result.press_class  = item.prev_class;
		result.clear_stamps = 1'b0;
		upd.we              = 1'b0;
		upd.value           = item.released_stamp;
		if (item.released_stamp != 32'd0) begin
			if (short_hold && gap_gt) begin
				result.press_class  = (item.prev_class == CLS_SUS_TRIPLE) ? CLS_DOUBLE : CLS_SHORT;
				result.clear_stamps = 1'b1;
			end else if (short_hold && gap_lt) begin
				case (item.prev_class)
					CLS_SUS_DOUBLE: begin
						if (same_rel) begin
							result.press_class = CLS_SUS_DOUBLE;
						end else begin
							result.press_class = CLS_SUS_TRIPLE;
							upd.we             = 1'b1;
						end
					end
					CLS_SUS_TRIPLE: begin
						result.press_class = same_rel ? CLS_SUS_TRIPLE : CLS_TRIPLE;
					end
					CLS_TRIPLE: begin
						result.press_class  = CLS_NONE;
						result.clear_stamps = 1'b1;
					end
					default: begin
						result.press_class = CLS_SUS_DOUBLE;
						upd.we             = 1'b1;
					end
				endcase
			end
		end else if (held_long) begin
			result.press_class = held_in_win ? CLS_LONG : CLS_NONE;
		end
	end

endmodule

`default_nettype wire

### rtl/button_click_classifier.sv
// Top level of the button click classifier: handshake, registers and state.
//
// Usage: the caller hands one button sample per transfer on the input channel
// (in_valid, in_stall, in_data): current time, press and release stamps and the
// class it got for the previous sample. For each sample the block returns one
// transfer on the output channel (out_valid, out_stall, out_data) holding the
// new class and a flag asking the caller to zero its stamps.
// Path: a sample is taken into the input register, classified from it, and its
// result is registered in the result register, which drives out_data.
// Throughput: one sample per cycle while the receiver does not stall; the
// remembered release stamp is updated in the same cycle that classifies a
// sample, so the next sample sees it at once.
// When the receiver stalls, the result register holds its value and the input
// register holds the next sample; in_stall rises only while both are full.
// Reset (arst_n low) empties both stages, clears the remembered release stamp
// and loads the default spacing, long-press and scan-interval values.
// Configuration: cfg_we writes cfg_data (24 bits) into register cfg_index;
// index 3 is ignored. Write only while no sample is in flight.
`default_nettype none

module button_click_classifier (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bcc_pkg::bcc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output bcc_pkg::bcc_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data
);
	import bcc_pkg::*;

	bcc_in_t     item_s1;
	logic        valid_s1;
	bcc_out_t    res_s2;
	logic        valid_s2;
	bcc_cfg_t    cfg_q;
	logic [31:0] last_release_q;
	bcc_out_t    result;
	bcc_upd_t    upd;
	logic        adv_s1;
	logic        load_s1;

	// The input stage moves on when the result register is empty or draining.
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign load_s1  = in_valid && !in_stall;

	bcc_classify u_classify (
		.item         (item_s1),
		.cfg          (cfg_q),
		.last_release (last_release_q),
		.result       (result),
		.upd          (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= in_data;
		end
		if (adv_s1) begin
			res_s2 <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_release_q <= 32'd0;
		end else if (adv_s1 && upd.we) begin
			last_release_q <= upd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.join_gap_us      <= SPACING_RST;
			cfg_q.long_press_us    <= LONG_RST;
			cfg_q.scan_interval_us <= SCAN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPACING: cfg_q.join_gap_us      <= cfg_data;
				REG_LONG:    cfg_q.long_press_us    <= cfg_data;
				REG_SCAN:    cfg_q.scan_interval_us <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// A sample held in the input stage is never dropped.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("input stage lost a sample");

	// Every stamp update comes with a suspect class on the output.
	a_upd_class: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && upd.we |=> valid_s2 &&
			(res_s2.press_class == CLS_SUS_DOUBLE || res_s2.press_class == CLS_SUS_TRIPLE))
		else $error("stamp update without suspect class");

	// Clearing the stamps only goes with short, double or none.
	a_clear_class: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.clear_stamps |->
			(res_s2.press_class == CLS_SHORT || res_s2.press_class == CLS_DOUBLE ||
			 res_s2.press_class == CLS_NONE))
		else $error("clear flag with unexpected class");

	// The remembered stamp only ever takes a nonzero release time.
	a_rel_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(last_release_q) |-> last_release_q != 32'd0)
		else $error("remembered release stamp set to zero");

endmodule

`default_nettype wire
